FILE: design/nfcrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfcrp_pkg: shared types and constants of the response frame parser
// Word formats, parser phases, end status codes and register indexes.
// ----------------------------------------------------------------------------
package nfcrp_pkg;

  localparam logic [7:0] PREAMBLE_BYTE = 8'h00;
  localparam logic [7:0] START_BYTE    = 8'hFF;
  localparam logic [7:0] MIN_LENGTH    = 8'd2;   // TFI and CMD

  localparam logic [7:0] EXPECTED_CODE_RST    = 8'd0;
  localparam logic [7:0] DIRECTION_CODE_RST   = 8'd213;
  localparam logic [7:0] PAYLOAD_CAPACITY_RST = 8'd255;

  typedef enum logic [1:0] {
    CFG_EXPECTED_CODE    = 2'd0,
    CFG_DIRECTION_CODE   = 2'd1,
    CFG_PAYLOAD_CAPACITY = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_PRE1   = 4'd1,
    PH_START2 = 4'd2,
    PH_LEN    = 4'd3,
    PH_LCS    = 4'd4,
    PH_TFI    = 4'd5,
    PH_CMD    = 4'd6,
    PH_DATA   = 4'd7,
    PH_DCS    = 4'd8,
    PH_POST   = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOSPACE = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_word_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       frame_done;
    logic [1:0] frame_status;
    logic [7:0] payload_length;
  } out_word_t;

  typedef struct packed {
    logic [7:0] expected_code;
    logic [7:0] direction_code;
    logic [7:0] payload_capacity;
  } cfg_t;

endpackage

FILE: design/nfcrp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfcrp_if: valid/ready channels of the response frame parser
// Input channel carries received bytes, output channel carries results.
// ----------------------------------------------------------------------------
interface nfcrp_in_if;
  logic                valid;
  logic                ready;
  nfcrp_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface nfcrp_out_if;
  logic                 valid;
  logic                 ready;
  nfcrp_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/nfcrp_response_frame_parser_unit.sv
`timescale 1ns / 1ps
// A result word is registered and appears on the output in the cycle after its byte is taken.
// Throughput: one byte per cycle; the parser state machine handles each byte
// as it is taken, and a new byte is taken in the same cycle that a waiting
// result word leaves. While a result word is stalled, no byte is taken.
// Reset (rst_n low, synchronous): parser idle, output empty, registers back to
// expected code 0, direction code 213, payload capacity 255.
// ----------------------------------------------------------------------------
// nfc_response_frame_parser_unit: information frame parser, top level
// Configuration registers, byte handshake, parser and output register.
// ----------------------------------------------------------------------------
module nfc_response_frame_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  nfcrp_in_if.sink    in_ch,
  nfcrp_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [7:0]  cfg_wdata
);
  import nfcrp_pkg::*;

  cfg_t      cfg_r;
  logic      out_valid_r;
  out_word_t out_word_r;
  logic      in_ready;
  logic      take;
  logic      res_valid;
  out_word_t res;

  assign in_ready     = !out_valid_r || out_ch.ready;
  assign take         = in_ch.valid && in_ready;
  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_code    <= EXPECTED_CODE_RST;
      cfg_r.direction_code   <= DIRECTION_CODE_RST;
      cfg_r.payload_capacity <= PAYLOAD_CAPACITY_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_EXPECTED_CODE:    cfg_r.expected_code    <= cfg_wdata;
        CFG_DIRECTION_CODE:   cfg_r.direction_code   <= cfg_wdata;
        CFG_PAYLOAD_CAPACITY: cfg_r.payload_capacity <= cfg_wdata;
        default:              cfg_r                  <= cfg_r;
      endcase
    end
  end

  nfcrp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (take),
    .word      (in_ch.data),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= res_valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result word payload, no reset needed
  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_word_r <= res;
    end
  end

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    take && res_valid |=> out_valid_r && out_word_r == $past(res))
    else $error("result word not registered");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while result word stalled");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_idx == CFG_DIRECTION_CODE |=> cfg_r.direction_code == $past(cfg_wdata))
    else $error("direction code write lost");

endmodule

FILE: design/nfcrp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfcrp_parser: byte-wise frame parser state machine
// Updates the parse state on each accepted byte and computes its result.
// ----------------------------------------------------------------------------
module nfcrp_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  nfcrp_pkg::in_word_t  word,
  input  nfcrp_pkg::cfg_t      cfg,
  output logic                 res_valid,
  output nfcrp_pkg::out_word_t res
);
  import nfcrp_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] remaining_r, remaining_nxt;
  logic [7:0] length_r, length_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       drain_r, drain_nxt;
  logic [7:0] index_r, index_nxt;

  logic [7:0] b;
  logic [7:0] plen;
  logic [7:0] rem_dec;
  logic       lcs_bad;
  logic       dcs_bad;

  assign b       = word.rx_byte;
  assign plen    = length_r - MIN_LENGTH;
  assign rem_dec = remaining_r - 8'd1;
  assign lcs_bad = ((length_r + b) != 8'd0) || (length_r < MIN_LENGTH);
  assign dcs_bad = !drain_r && ((sum_r + b) != 8'd0);

  // next state
  always_comb begin
    phase_nxt     = phase_r;
    remaining_nxt = remaining_r;
    length_nxt    = length_r;
    sum_nxt       = sum_r;
    drain_nxt     = drain_r;
    index_nxt     = index_r;
    if (word.frame_start) begin
      remaining_nxt = 8'd0;
      length_nxt    = 8'd0;
      sum_nxt       = 8'd0;
      drain_nxt     = 1'b0;
      index_nxt     = 8'd0;
      phase_nxt     = (b != PREAMBLE_BYTE) ? PH_IDLE : PH_PRE1;
    end else begin
      unique case (phase_r)
        PH_IDLE:   phase_nxt = PH_IDLE;
        PH_PRE1:   phase_nxt = (b != PREAMBLE_BYTE) ? PH_IDLE : PH_START2;
        PH_START2: phase_nxt = (b != START_BYTE) ? PH_IDLE : PH_LEN;
        PH_LEN: begin
          length_nxt = b;
          phase_nxt  = PH_LCS;
        end
        PH_LCS:    phase_nxt = lcs_bad ? PH_IDLE : PH_TFI;
        PH_TFI:    phase_nxt = (b != cfg.direction_code) ? PH_IDLE : PH_CMD;
        PH_CMD: begin
          if (b != cfg.expected_code) begin
            phase_nxt = PH_IDLE;
          end else begin
            drain_nxt     = plen > cfg.payload_capacity;
            sum_nxt       = cfg.direction_code + cfg.expected_code;
            remaining_nxt = plen;
            index_nxt     = 8'd0;
            phase_nxt     = (plen == 8'd0) ? PH_DCS : PH_DATA;
          end
        end
        PH_DATA: begin
          remaining_nxt = rem_dec;
          if (rem_dec == 8'd0) phase_nxt = PH_DCS;
          if (!drain_r) begin
            sum_nxt   = sum_r + b;
            index_nxt = index_r + 8'd1;
          end
        end
        PH_DCS:    phase_nxt = dcs_bad ? PH_IDLE : PH_POST;
        PH_POST:   phase_nxt = PH_IDLE;
        default:   phase_nxt = PH_IDLE;
      endcase
    end
  end

  // result of the byte
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    if (word.frame_start) begin
      if (b != PREAMBLE_BYTE) begin
        res_valid        = 1'b1;
        res.frame_done   = 1'b1;
        res.frame_status = ST_INVALID;
      end
    end else begin
      unique case (phase_r)
        PH_PRE1: begin
          res_valid = (b != PREAMBLE_BYTE);
        end
        PH_START2: begin
          res_valid = (b != START_BYTE);
        end
        PH_LCS: begin
          res_valid = lcs_bad;
        end
        PH_TFI: begin
          res_valid = (b != cfg.direction_code);
        end
        PH_CMD: begin
          res_valid = (b != cfg.expected_code);
        end
        PH_DCS: begin
          res_valid = dcs_bad;
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
      if (res_valid) begin
        res.frame_done   = 1'b1;
        res.frame_status = ST_INVALID;
      end
      if (phase_r == PH_DATA && !drain_r) begin
        res_valid         = 1'b1;
        res.payload_valid = 1'b1;
        res.payload_byte  = b;
        res.payload_index = index_r;
      end
      if (phase_r == PH_POST) begin
        res_valid        = 1'b1;
        res.frame_done   = 1'b1;
        res.frame_status = drain_r ? ST_NOSPACE : ST_OK;
        res.payload_length = drain_r ? 8'd0 : plen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      remaining_r <= 8'd0;
      length_r    <= 8'd0;
      sum_r       <= 8'd0;
      drain_r     <= 1'b0;
      index_r     <= 8'd0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      remaining_r <= remaining_nxt;
      length_r    <= length_nxt;
      sum_r       <= sum_nxt;
      drain_r     <= drain_nxt;
      index_r     <= index_nxt;
    end
  end

  a_payload_only_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_valid && res.payload_valid |-> phase_r == PH_DATA && !drain_r)
    else $error("payload word outside data phase");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_valid && res.frame_done |=> phase_r == PH_IDLE)
    else $error("parser not idle after frame end");

  a_ok_only_from_post: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_valid && res.frame_done && res.frame_status == ST_OK
      |-> phase_r == PH_POST && !word.frame_start)
    else $error("ok status outside postamble");

endmodule

FILE: verif/nfc_response_frame_parser_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfc_response_frame_parser_unit_test: self-checking bench of the frame parser
// Sends whole frames, broken frames and stray bytes over the byte channel.
// Each taken byte runs through a local copy of the parser. The words it should
// produce are queued and compared field by field with the words that come out.
// ----------------------------------------------------------------------------
module nfc_response_frame_parser_unit_test;
  import nfcrp_pkg::*;

  typedef enum int {
    FLAW_NONE, FLAW_PRE0, FLAW_PRE1, FLAW_START, FLAW_LCS,
    FLAW_TFI, FLAW_CMD, FLAW_DCS, FLAW_CUT
  } flaw_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [7:0] cfg_wdata;

  nfcrp_in_if  in_ch();
  nfcrp_out_if out_ch();

  nfc_response_frame_parser_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // local parser copy: registers and state
  logic [7:0] want_code;
  logic [7:0] dir_code;
  logic [7:0] capacity;
  phase_t     frame_phase;
  logic [7:0] bytes_left;
  logic [7:0] len_byte;
  logic [7:0] data_sum;
  logic       draining;
  logic [7:0] payload_pos;

  out_word_t   due_words[$];
  int unsigned mismatches;
  int unsigned bytes_taken;
  int unsigned burst_left;
  bit          gaps_on;
  bit          stalls_on;
  int unsigned stall_left;
  int unsigned run_left;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // one parser step; returns 1 when the byte yields an output word
  function automatic bit parse_byte(input logic [7:0] b, input logic st,
                                    output out_word_t r);
    logic [7:0] plen;
    bit         fin;
    status_t    stat;
    r    = '0;
    fin  = 1'b0;
    stat = ST_INVALID;
    if (st) begin
      bytes_left  = '0;
      len_byte    = '0;
      data_sum    = '0;
      draining    = 1'b0;
      payload_pos = '0;
      if (b != PREAMBLE_BYTE) fin = 1'b1;
      else frame_phase = PH_PRE1;
    end else begin
      case (frame_phase)
        PH_PRE1: if (b != PREAMBLE_BYTE) fin = 1'b1; else frame_phase = PH_START2;
        PH_START2: if (b != START_BYTE) fin = 1'b1; else frame_phase = PH_LEN;
        PH_LEN: begin
          len_byte    = b;
          frame_phase = PH_LCS;
        end
        PH_LCS: begin
          if (8'(len_byte + b) != 8'd0 || len_byte < MIN_LENGTH) fin = 1'b1;
          else frame_phase = PH_TFI;
        end
        PH_TFI: if (b != dir_code) fin = 1'b1; else frame_phase = PH_CMD;
        PH_CMD: begin
          if (b != want_code) begin
            fin = 1'b1;
          end else begin
            plen        = len_byte - MIN_LENGTH;
            draining    = (plen > capacity);
            data_sum    = 8'(dir_code + want_code);
            bytes_left  = plen;
            payload_pos = '0;
            frame_phase = (plen == 8'd0) ? PH_DCS : PH_DATA;
          end
        end
        PH_DATA: begin
          bytes_left = bytes_left - 8'd1;
          if (bytes_left == 8'd0) frame_phase = PH_DCS;
          if (!draining) begin
            data_sum        = 8'(data_sum + b);
            r.payload_valid = 1'b1;
            r.payload_byte  = b;
            r.payload_index = payload_pos;
            payload_pos     = payload_pos + 8'd1;
          end
        end
        PH_DCS: begin
          if (!draining && 8'(data_sum + b) != 8'd0) fin = 1'b1;
          else frame_phase = PH_POST;
        end
        PH_POST: begin
          fin = 1'b1;
          // postamble value itself is never checked
          if (draining) begin
            stat = ST_NOSPACE;
          end else begin
            stat             = ST_OK;
            r.payload_length = len_byte - MIN_LENGTH;
          end
        end
        default: frame_phase = PH_IDLE;
      endcase
    end
    if (fin) begin
      r.frame_done   = 1'b1;
      r.frame_status = stat;
      frame_phase    = PH_IDLE;
    end
    return fin || r.payload_valid;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t ns: mismatch on %s, got %02h want %02h", $time, what, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    out_word_t got;
    out_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (due_words.size() == 0) begin
        report_mismatch("word with none due", got.payload_byte, 8'h00);
      end else begin
        want = due_words.pop_front();
        if (got.payload_valid != want.payload_valid)
          report_mismatch("payload_valid", 8'(got.payload_valid), 8'(want.payload_valid));
        if (got.payload_byte != want.payload_byte)
          report_mismatch("payload_byte", got.payload_byte, want.payload_byte);
        if (got.payload_index != want.payload_index)
          report_mismatch("payload_index", got.payload_index, want.payload_index);
        if (got.frame_done != want.frame_done)
          report_mismatch("frame_done", 8'(got.frame_done), 8'(want.frame_done));
        if (got.frame_status != want.frame_status)
          report_mismatch("frame_status", 8'(got.frame_status), 8'(want.frame_status));
        if (got.payload_length != want.payload_length)
          report_mismatch("payload_length", got.payload_length, want.payload_length);
      end
    end
  end

  // receiver: ready runs and stall runs of random length
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if (run_left != 0) begin
      out_ch.ready <= 1'b1;
      run_left--;
    end else begin
      run_left   = $urandom_range(1, 24);
      stall_left = !stalls_on ? 0 :
                   ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : $urandom_range(0, 2);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic st);
    in_word_t    w;
    out_word_t   r;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    w.rx_byte     = b;
    w.frame_start = st;
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    if (st || frame_phase != PH_IDLE) bytes_taken++;
    if (parse_byte(b, st, r)) due_words.push_back(r);
  endtask

  // hold the sender until every due word is out and the parser is quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] ec, input logic [7:0] dc,
                            input logic [7:0] cap);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_EXPECTED_CODE;
    cfg_wdata <= ec;
    @(posedge clk);
    cfg_idx   <= CFG_DIRECTION_CODE;
    cfg_wdata <= dc;
    @(posedge clk);
    cfg_idx   <= CFG_PAYLOAD_CAPACITY;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
    want_code = ec;
    dir_code  = dc;
    capacity  = cap;
  endtask

  // builds a frame for the current codes, spoils it as asked, sends it
  task automatic send_frame(input logic [7:0] len, input flaw_t flaw);
    logic [7:0]  fb[$];
    logic [7:0]  sum;
    logic [7:0]  v;
    int unsigned n;
    int unsigned i;
    fb  = '{PREAMBLE_BYTE, PREAMBLE_BYTE, START_BYTE, len, 8'd0 - len, dir_code, want_code};
    n   = (len >= MIN_LENGTH) ? 32'(len - MIN_LENGTH) : 0;
    sum = 8'(dir_code + want_code);
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: v = 8'h00;
        1: v = 8'hFF;
        default: v = 8'($urandom);
      endcase
      sum = 8'(sum + v);
      fb.push_back(v);
    end
    fb.push_back(8'd0 - sum);
    fb.push_back(8'($urandom));
    case (flaw)
      FLAW_PRE0:  fb[0] = 8'($urandom_range(1, 255));
      FLAW_PRE1:  fb[1] = 8'($urandom_range(1, 255));
      FLAW_START: fb[2] = 8'($urandom_range(0, 254));
      FLAW_LCS:   fb[4] = fb[4] + 8'($urandom_range(1, 255));
      FLAW_TFI:   fb[5] = fb[5] + 8'($urandom_range(1, 255));
      FLAW_CMD:   fb[6] = fb[6] + 8'($urandom_range(1, 255));
      FLAW_DCS:   fb[7 + n] = fb[7 + n] + 8'($urandom_range(1, 255));
      FLAW_CUT:   fb = fb[0 : $urandom_range(0, fb.size() - 2)];
      default: ;
    endcase
    for (i = 0; i < fb.size(); i++) send_byte(fb[i], i == 0);
  endtask

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic test_idle_and_defaults();
    // stray bytes while idle give nothing
    send_byte(8'hAB, 1'b0);
    send_byte(8'h00, 1'b0);
    send_frame(8'd2, FLAW_NONE);
  endtask

  task automatic test_header_errors();
    settle();
    set_config(8'hFF, 8'h00, 8'hFF);
    send_frame(8'd2, FLAW_PRE0);
    send_frame(8'd2, FLAW_PRE1);
    send_frame(8'd2, FLAW_START);
    send_frame(8'd2, FLAW_LCS);
    send_frame(8'd2, FLAW_TFI);
    send_frame(8'd2, FLAW_CMD);
  endtask

  task automatic test_length_cases();
    send_frame(8'd0, FLAW_NONE);
    send_frame(8'd1, FLAW_NONE);
    send_frame(8'd4, FLAW_NONE);
    send_frame(8'd3, FLAW_DCS);
    settle();
    set_config(8'h00, 8'hFF, 8'h00);
    send_frame(8'd3, FLAW_NONE);
    send_frame(8'd3, FLAW_DCS);     // drained frames skip the data checksum
    send_frame(8'd2, FLAW_NONE);
    settle();
    set_config(8'h5A, 8'hD5, 8'hFF);
    send_frame(8'd255, FLAW_NONE);
  endtask

  task automatic test_restart();
    send_frame(8'd6, FLAW_CUT);
    send_frame(8'd3, FLAW_NONE);
    send_frame(8'd2, FLAW_CUT);
    send_frame(8'd2, FLAW_NONE);
  endtask

  task automatic test_random_traffic();
    int unsigned goal;
    int unsigned k;
    int unsigned round;
    logic [7:0]  len;
    flaw_t       flaw;
    for (round = 0; round < 6; round++) begin
      settle();
      case (round)
        0: set_config(8'hFF, 8'hFF, 8'h00);
        1: set_config(8'h00, 8'h00, 8'hFF);
        default: set_config(pick_code(), pick_code(),
                            ($urandom_range(0, 2) == 0) ? pick_code() : 8'($urandom_range(0, 16)));
      endcase
      gaps_on   = (round != 2);
      stalls_on = (round != 3);
      goal      = bytes_taken + 110;
      while (bytes_taken < goal) begin
        k = $urandom_range(0, 99);
        if (k < 8) begin
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 9) == 0);
        end else begin
          k = $urandom_range(0, 99);
          if (k < 75) len = 8'($urandom_range(2, 12));
          else if (k < 87) len = 8'($urandom_range(13, 40));
          else if (k < 92) len = 8'($urandom_range(0, 1));
          else if (k < 97) len = 8'($urandom);
          else len = 8'($urandom_range(41, 255));
          flaw = ($urandom_range(0, 9) < 7) ? FLAW_NONE :
                 flaw_t'($urandom_range(FLAW_PRE0, FLAW_CUT));
          send_frame(len, flaw);
        end
        if ($urandom_range(0, 29) == 0) settle();
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_EXPECTED_CODE;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    want_code    = EXPECTED_CODE_RST;
    dir_code     = DIRECTION_CODE_RST;
    capacity     = PAYLOAD_CAPACITY_RST;
    frame_phase  = PH_IDLE;
    bytes_left   = '0;
    len_byte     = '0;
    data_sum     = '0;
    draining     = 1'b0;
    payload_pos  = '0;
    mismatches   = 0;
    bytes_taken  = 0;
    burst_left   = 0;
    gaps_on      = 1'b1;
    stalls_on    = 1'b1;
    stall_left   = 0;
    run_left     = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_and_defaults();
    test_header_errors();
    test_length_cases();
    test_restart();
    test_random_traffic();

    settle();
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #10000000;
    $display("timeout with %0d words still due", due_words.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
